FILE: design/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Item types, lead-byte ranges and codepoint limits shared by the decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  // Lead-byte class boundaries
  localparam logic [7:0] LeadTwo   = 8'hc0;
  localparam logic [7:0] LeadThree = 8'he0;
  localparam logic [7:0] LeadFour  = 8'hf0;
  localparam logic [7:0] LeadBad   = 8'hf8;

  // Continuation byte pattern
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;

  // Sequence lengths
  localparam logic [2:0] LenOne    = 3'd1;
  localparam logic [2:0] LenTwo    = 3'd2;
  localparam logic [2:0] LenThree  = 3'd3;
  localparam logic [2:0] LenFour   = 3'd4;

  // Codepoint limits
  localparam logic [20:0] CpReplace = 21'h00fffd;
  localparam logic [20:0] CpMin2    = 21'h000080;
  localparam logic [20:0] CpMin3    = 21'h000800;
  localparam logic [20:0] CpMin4    = 21'h010000;
  localparam logic [20:0] CpMax     = 21'h10ffff;

  // Input item: byte window at the read position
  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [2:0] bytes_available;
  } in_t;

  // Result item
  typedef struct packed {
    logic [20:0] codepoint;
    logic [2:0]  consumed;
  } out_t;

  // Classified window after the first stage
  typedef struct packed {
    logic       pass;     // ASCII or stray continuation byte
    logic       seq_ok;   // valid lead, enough bytes, good continuations
    logic [2:0] need;     // sequence length implied by the lead
    logic [7:0] lead;
    logic [5:0] p1;
    logic [5:0] p2;
    logic [5:0] p3;
  } cls_t;

  // Assembled sequence after the second stage
  typedef struct packed {
    logic        pass;
    logic        good;
    logic [2:0]  need;
    logic [7:0]  lead;
    logic [20:0] value;
  } asm_t;

endpackage

FILE: design/utf8_validating_decoder_unit.sv
// Throughput: one item per cycle while the output is not stalled; three
// register stages (classify, assemble, select) each advance independently,
// so bubbles fill behind a stalled output.
// Reset: rst_ni clears all stage valid bits asynchronously; no other state.
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes one codepoint from a four-byte window, rejecting truncated, badly
// continued, overlong and out-of-range sequences with U+FFFD, length 1.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  u8dec_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output u8dec_pkg::out_t out_data_o
);

  logic             s1_valid_q;
  u8dec_pkg::cls_t  s1_q;
  u8dec_pkg::cls_t  s1_d;
  logic             s2_valid_q;
  u8dec_pkg::asm_t  s2_q;
  u8dec_pkg::asm_t  s2_d;
  logic             out_valid_q;
  u8dec_pkg::out_t  out_q;
  u8dec_pkg::out_t  out_d;
  logic             s1_ready;
  logic             s2_ready;
  logic             out_ready;

  // Each stage may load when empty or when its content moves on
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // Stage 1: classify the window
  u8dec_classify u_classify (
    .win_i (in_data_i),
    .cls_o (s1_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: assemble the value and check overlong and range limits
  always_comb begin
    s2_d.pass = s1_q.pass;
    s2_d.need = s1_q.need;
    s2_d.lead = s1_q.lead;
    case (s1_q.need)
      u8dec_pkg::LenTwo: begin
        s2_d.value = {10'd0, s1_q.lead[4:0], s1_q.p1};
        s2_d.good  = s1_q.seq_ok && (s2_d.value >= u8dec_pkg::CpMin2);
      end
      u8dec_pkg::LenThree: begin
        s2_d.value = {5'd0, s1_q.lead[3:0], s1_q.p1, s1_q.p2};
        s2_d.good  = s1_q.seq_ok && (s2_d.value >= u8dec_pkg::CpMin3);
      end
      default: begin
        s2_d.value = {s1_q.lead[2:0], s1_q.p1, s1_q.p2, s1_q.p3};
        s2_d.good  = s1_q.seq_ok && (s2_d.value >= u8dec_pkg::CpMin4) &&
                     (s2_d.value <= u8dec_pkg::CpMax);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: select pass-through, decoded value or replacement
  always_comb begin
    if (s2_q.pass) begin
      out_d.codepoint = {13'd0, s2_q.lead};
      out_d.consumed  = u8dec_pkg::LenOne;
    end else if (s2_q.good) begin
      out_d.codepoint = s2_q.value;
      out_d.consumed  = s2_q.need;
    end else begin
      out_d.codepoint = u8dec_pkg::CpReplace;
      out_d.consumed  = u8dec_pkg::LenOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Consumed count stays within one to four
  a_consumed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.consumed >= u8dec_pkg::LenOne &&
                     out_data_o.consumed <= u8dec_pkg::LenFour))
    else $error("consumed out of range");

  // Never emit a codepoint above the Unicode limit
  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.codepoint <= u8dec_pkg::CpMax))
    else $error("codepoint above U+10FFFF");

  // A multi-byte result is never an ASCII codepoint
  a_multi_not_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.consumed != u8dec_pkg::LenOne) |->
      (out_data_o.codepoint >= u8dec_pkg::CpMin2))
    else $error("multi-byte result below U+0080");

  // A stalled result keeps stage 2 filled
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && s2_valid_q) |=> s2_valid_q)
    else $error("stage 2 item lost under stall");
`endif

endmodule

FILE: design/u8dec_classify.sv
// ----------------------------------------------------------------------------
// UTF-8 window classifier
// Finds the sequence length from the lead byte and checks availability and
// continuation bytes; strips the continuation tags off the payload bytes.
// ----------------------------------------------------------------------------
module u8dec_classify (
  input  u8dec_pkg::in_t  win_i,
  output u8dec_pkg::cls_t cls_o
);

  logic [7:0] c;
  logic [2:0] need;
  logic       cont1;
  logic       cont2;
  logic       cont3;
  logic       avail_ok;

  assign c = win_i.lead_byte;

  // Pick the length implied by the lead
  always_comb begin
    if (c < u8dec_pkg::LeadThree) begin
      need = u8dec_pkg::LenTwo;
    end else if (c < u8dec_pkg::LeadFour) begin
      need = u8dec_pkg::LenThree;
    end else begin
      need = u8dec_pkg::LenFour;
    end
  end

  // Check continuation tags
  assign cont1 = (win_i.second_byte & u8dec_pkg::ContMask) == u8dec_pkg::ContTag;
  assign cont2 = (win_i.third_byte  & u8dec_pkg::ContMask) == u8dec_pkg::ContTag;
  assign cont3 = (win_i.fourth_byte & u8dec_pkg::ContMask) == u8dec_pkg::ContTag;

  // A count of zero fails every multi-byte need; counts above four pass all
  assign avail_ok = win_i.bytes_available >= need;

  always_comb begin
    cls_o.pass   = c < u8dec_pkg::LeadTwo;
    cls_o.seq_ok = (c < u8dec_pkg::LeadBad) && avail_ok && cont1 &&
                   ((need < u8dec_pkg::LenThree) || cont2) &&
                   ((need < u8dec_pkg::LenFour)  || cont3);
    cls_o.need   = need;
    cls_o.lead   = c;
    cls_o.p1     = win_i.second_byte[5:0];
    cls_o.p2     = win_i.third_byte[5:0];
    cls_o.p3     = win_i.fourth_byte[5:0];
  end

endmodule
